FILE: hdl/dds_tw_pkg.sv
// shared types and constants for the dds tuning word calculator
`default_nettype none

package dds_tw_pkg;

   localparam int EXT_CLOCK_BITS    = 27;
   localparam int MULT_BITS         = 5;
   localparam int FREQ_BITS         = 31;
   localparam int REF_BITS          = EXT_CLOCK_BITS + MULT_BITS;
   localparam int REQ_TDATA_BITS    = ((FREQ_BITS + 7) / 8) * 8;
   localparam int DEFAULT_WORD_BITS = 48;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_EXT_CLOCK  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_MULTIPLIER = CSR_INDEX_BITS'(1);

   localparam logic [EXT_CLOCK_BITS-1:0] EXT_CLOCK_RESET = EXT_CLOCK_BITS'(66000000);
   localparam logic [MULT_BITS-1:0]      MULT_RESET      = MULT_BITS'(4);
   localparam logic [MULT_BITS-1:0]      MULT_LOW        = MULT_BITS'(4);
   localparam logic [MULT_BITS-1:0]      MULT_HIGH       = MULT_BITS'(20);

   typedef struct packed {
      logic load;
      logic mult;
      logic init;
      logic step;
      logic round;
      logic publish;
   } dds_tw_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dds_tw_stat_type;

endpackage

`default_nettype wire

FILE: hdl/dds_tw_dp.sv
// datapath: config registers, reference multiply, restoring divider, rounding, output register
`default_nettype none

module dds_tw_dp #(
   parameter int WORD_BITS = dds_tw_pkg::DEFAULT_WORD_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire dds_tw_pkg::dds_tw_cmd_type             cmd,
   output dds_tw_pkg::dds_tw_stat_type                 stat,
   input  wire logic [dds_tw_pkg::FREQ_BITS-1:0]       freq,
   input  wire logic                                   csr_write,
   input  wire logic [dds_tw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [dds_tw_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic                                   rsp_tready,
   output logic                                        rsp_valid,
   output logic [WORD_BITS-1:0]                        rsp_word,
   output logic                                        rsp_ovf
);
   import dds_tw_pkg::*;

   logic [EXT_CLOCK_BITS-1:0] ext_ff, ext_in;
   logic [MULT_BITS-1:0]      mult_ff, mult_in, mult_raw;
   logic [FREQ_BITS-1:0]      freq_ff, freq_in;
   logic [REF_BITS-1:0]       ref_ff, ref_in;
   logic [REF_BITS-1:0]       rem_ff, rem_in;
   logic [WORD_BITS-1:0]      quo_ff, quo_in;
   logic                      ovf_ff, ovf_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]      rsp_word_ff, rsp_word_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic [REF_BITS:0]         rem2;
   logic [REF_BITS:0]         diff;
   logic                      ge;
   logic                      round_up;
   logic [WORD_BITS:0]        sum;
   logic                      ovf_final;

   always_comb begin
      mult_raw = csr_wdata[MULT_BITS-1:0];
      ext_in   = ext_ff;
      mult_in  = mult_ff;
      if (csr_write && csr_index == REG_EXT_CLOCK) begin
         ext_in = csr_wdata[EXT_CLOCK_BITS-1:0];
      end
      if (csr_write && csr_index == REG_MULTIPLIER) begin
         if (mult_raw < MULT_LOW) begin
            mult_in = MULT_LOW;
         end else if (mult_raw > MULT_HIGH) begin
            mult_in = MULT_HIGH;
         end else begin
            mult_in = mult_raw;
         end
      end
   end

   always_comb begin
      rem2      = {rem_ff, 1'b0};
      diff      = rem2 - {1'b0, ref_ff};
      ge        = rem2 >= {1'b0, ref_ff};
      round_up  = rem_ff > (ref_ff >> 1);
      sum       = {1'b0, quo_ff} + (WORD_BITS + 1)'(round_up);
      ovf_final = ovf_ff | sum[WORD_BITS];

      freq_in = cmd.load ? freq : freq_ff;
      ref_in  = cmd.mult ? REF_BITS'(ext_ff) * REF_BITS'(mult_ff) : ref_ff;

      rem_in = rem_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      if (cmd.init) begin
         rem_in = REF_BITS'(freq_ff);
         quo_in = '0;
         ovf_in = (ref_ff == '0) || (REF_BITS'(freq_ff) >= ref_ff);
      end else if (cmd.step) begin
         rem_in = ge ? diff[REF_BITS-1:0] : rem2[REF_BITS-1:0];
         quo_in = {quo_ff[WORD_BITS-2:0], ge};
      end else if (cmd.round) begin
         ovf_in = ovf_final;
         quo_in = ovf_final ? '1 : sum[WORD_BITS-1:0];
      end

      rsp_word_in  = cmd.publish ? quo_ff : rsp_word_ff;
      rsp_ovf_in   = cmd.publish ? ovf_ff : rsp_ovf_ff;
      rsp_valid_in = cmd.publish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff       <= EXT_CLOCK_RESET;
         mult_ff      <= MULT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         ext_ff       <= ext_in;
         mult_ff      <= mult_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff     <= freq_in;
      ref_ff      <= ref_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      ovf_ff      <= ovf_in;
      rsp_word_ff <= rsp_word_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign stat.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_word_ff;
   assign rsp_ovf       = rsp_ovf_ff;

endmodule

`default_nettype wire

FILE: hdl/dds_tw_ctrl.sv
// controller: sequences load, multiply, divide steps, rounding and hand-off
`default_nettype none

module dds_tw_ctrl #(
   parameter int WORD_BITS = dds_tw_pkg::DEFAULT_WORD_BITS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   output dds_tw_pkg::dds_tw_cmd_type       cmd,
   input  wire dds_tw_pkg::dds_tw_stat_type stat
);
   import dds_tw_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MULT  = 3'd1;
   localparam logic [2:0] S_INIT  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_ROUND = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) begin
               state_in = S_MULT;
            end
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

FILE: hdl/dds_tuning_word_calc_core.sv
// top level of the dds tuning word calculator
//
// req channel: one word per wanted output frequency in Hz (req_tdata[30:0]).
// rsp channel: one word per request, the tuning word f * 2^WORD_BITS /
// (ext_clock * multiplier) rounded to nearest, ties down, in rsp_tdata, and
// rsp_tuser high when the word was saturated to all ones.
// csr channel: index 0 external clock in Hz, index 1 multiplier (clamped
// to 4..20); other indexes are ignored; csr_ready is always high.
// sequence: after the request is taken, a multiply state, a setup state,
// WORD_BITS restoring divider steps, a rounding state and a hand-off
// state that waits while the previous word is not yet taken.
// the divider retires one quotient bit per cycle; a new request is taken
// only in the idle state, after the previous one is handed off, and
// req_tready is high while idle.
// a finished word waits in the output register; the next request is
// taken and computed meanwhile, and its result holds until rsp_tready.
// reset (synchronous, active high) drops rsp_tvalid, idles the controller
// and loads the registers with 66000000 Hz and multiplier 4.
`default_nettype none

module dds_tuning_word_calc_core #(
   parameter int WORD_BITS = dds_tw_pkg::DEFAULT_WORD_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [dds_tw_pkg::REQ_TDATA_BITS-1:0]  req_tdata,  // freq_out_hz
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [((WORD_BITS+7)/8)*8-1:0]              rsp_tdata,  // tuning_word
   output logic                                        rsp_tuser,  // word_overflow
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [dds_tw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [dds_tw_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import dds_tw_pkg::*;

   localparam int RSP_TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;

   dds_tw_cmd_type       cmd;
   dds_tw_stat_type      stat;
   logic [WORD_BITS-1:0] rsp_word;
   logic                 rsp_ovf;

   assign csr_ready = 1'b1;

   dds_tw_ctrl #(
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   dds_tw_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .freq       (req_tdata[FREQ_BITS-1:0]),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_word   (rsp_word),
      .rsp_ovf    (rsp_ovf)
   );

   assign rsp_tdata = RSP_TDATA_BITS'(rsp_word);
   assign rsp_tuser = rsp_ovf;

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_word == {WORD_BITS{1'b1}})
      else $error("saturated word is not all ones");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a computation runs");

   a_result_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result word appeared without a computation");

endmodule

`default_nettype wire

FILE: bench/dds_tuning_word_calc_core_tb.sv
// self-checking testbench for the dds tuning word calculator core
`timescale 1ns / 100ps

module dds_tuning_word_calc_core_tb;
   import dds_tw_pkg::*;

   localparam int TW_BITS        = DEFAULT_WORD_BITS;
   localparam int RSP_TDATA_BITS = ((TW_BITS + 7) / 8) * 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = TW_BITS + 12;
   localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;

   typedef struct packed {
      logic [TW_BITS-1:0] tuning_word;
      logic               word_overflow;
   } tuning_result_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   logic [EXT_CLOCK_BITS-1:0] ext_clock_hz = EXT_CLOCK_RESET;
   logic [MULT_BITS-1:0]      mult_setting = MULT_RESET;

   logic [FREQ_BITS-1:0] freq_backlog[$];
   tuning_result_type    expected_words[$];
   tuning_result_type    oldest_word;
   int                   send_idle_pct = 17;
   int                   recv_idle_pct = 60;
   int                   fail_count    = 0;
   int                   quiet_cycles  = 0;

   dds_tuning_word_calc_core #(
      .WORD_BITS(TW_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [31:0] reference_hz();
      return 32'(ext_clock_hz) * 32'(mult_setting);
   endfunction

   // freq * 2^48 / reference, rounded to nearest with ties down, saturated
   function automatic tuning_result_type calc_tuning_word(logic [FREQ_BITS-1:0] freq);
      logic [31:0]            ref_hz;
      logic [FREQ_BITS+TW_BITS-1:0] dividend;
      logic [FREQ_BITS+TW_BITS-1:0] quot;
      logic [31:0]            remainder;
      logic [TW_BITS:0]       rounded;
      tuning_result_type      result;
      ref_hz = reference_hz();
      result.tuning_word   = '1;
      result.word_overflow = 1'b1;
      if (ref_hz != 0 && 32'(freq) < ref_hz) begin
         dividend  = {freq, {TW_BITS{1'b0}}};
         quot      = dividend / ref_hz;
         remainder = 32'(dividend % ref_hz);
         rounded   = {1'b0, quot[TW_BITS-1:0]};
         if (remainder > (ref_hz >> 1))
            rounded = rounded + 1'b1;
         if (!rounded[TW_BITS]) begin
            result.tuning_word   = rounded[TW_BITS-1:0];
            result.word_overflow = 1'b0;
         end
      end
      return result;
   endfunction

   function automatic logic [FREQ_BITS-1:0] pick_freq();
      logic [31:0] ref_hz;
      logic [32:0] near;
      int unsigned sel;
      ref_hz = reference_hz();
      sel    = $urandom_range(9);
      if (ref_hz == 0 || sel >= 7)
         return FREQ_BITS'($urandom());
      if (sel == 0)
         return FREQ_BITS'($urandom_range(255));
      if (sel >= 5) begin
         if (ref_hz < 3)
            near = 33'($urandom_range(6));
         else
            near = 33'(ref_hz) + 33'($urandom_range(6)) - 33'd3;
         if (near > 33'(FREQ_MAX))
            near = 33'(FREQ_MAX) - 33'($urandom_range(3));
         return near[FREQ_BITS-1:0];
      end
      if (ref_hz - 1 > 32'(FREQ_MAX))
         return FREQ_BITS'($urandom_range(32'(FREQ_MAX), 0));
      return FREQ_BITS'($urandom_range(ref_hz - 1, 0));
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_words.push_back(calc_tuning_word(req_tdata[FREQ_BITS-1:0]));
         if (!req_tvalid || req_tready) begin
            if (freq_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_TDATA_BITS-FREQ_BITS){1'b0}}, freq_backlog.pop_front()};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("tuning_word unexpected word: actual %h", rsp_tdata[TW_BITS-1:0]);
               fail_count++;
            end else begin
               oldest_word = expected_words.pop_front();
               if (rsp_tdata[TW_BITS-1:0] !== oldest_word.tuning_word) begin
                  $error("tuning_word mismatch: expected %h, actual %h",
                         oldest_word.tuning_word, rsp_tdata[TW_BITS-1:0]);
                  fail_count++;
               end
               if (rsp_tuser !== oldest_word.word_overflow) begin
                  $error("word_overflow mismatch: expected %b, actual %b",
                         oldest_word.word_overflow, rsp_tuser);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("dds_tuning_word_calc_core_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == REG_EXT_CLOCK) begin
         ext_clock_hz = data[EXT_CLOCK_BITS-1:0];
      end else if (index == REG_MULTIPLIER) begin
         if (data[MULT_BITS-1:0] < MULT_LOW)
            mult_setting = MULT_LOW;
         else if (data[MULT_BITS-1:0] > MULT_HIGH)
            mult_setting = MULT_HIGH;
         else
            mult_setting = data[MULT_BITS-1:0];
      end
   endtask

   // ext clock with random junk above the field
   task automatic write_ext_clock(input logic [EXT_CLOCK_BITS-1:0] hz);
      write_csr(REG_EXT_CLOCK, {5'($urandom()), hz});
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (freq_backlog.size() != 0 || req_tvalid || expected_words.size() != 0);
   endtask

   task automatic run_random(input int count);
      @(negedge clock);
      repeat (count) freq_backlog.push_back(pick_freq());
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 17;
      recv_idle_pct = 60;
      @(negedge clock);
      freq_backlog = '{31'd0, 31'd1, 31'd2, FREQ_MAX, 31'd263999999, 31'd264000000,
                       31'd264000001, 31'd132000000, 31'd131999999, 31'h55555555,
                       31'h2aaaaaaa, 31'd12345678, 31'd1000000};
      wait_idle();
      run_random(120);

      // smallest reference, multiplier clamped up
      write_ext_clock(27'd1);
      write_csr(REG_MULTIPLIER, 32'd0);
      @(negedge clock);
      freq_backlog = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5};
      wait_idle();
      run_random(100);

      write_ext_clock(27'd100000000);
      write_csr(REG_MULTIPLIER, 32'd31);
      run_random(150);

      // receiver idles lightly, sender heavily
      send_idle_pct = 60;
      recv_idle_pct = 17;
      write_csr(REG_EXT_CLOCK, 32'hffffffff);
      write_csr(REG_MULTIPLIER, 32'd21);
      run_random(150);

      // zero external clock
      write_ext_clock(27'd0);
      run_random(20);

      write_csr(CSR_INDEX_BITS'(15), $urandom());
      write_csr(CSR_INDEX_BITS'(2), $urandom());
      write_csr(REG_MULTIPLIER, 32'hffffffe5);
      write_ext_clock(27'($urandom_range(100000000, 1)));
      run_random(150);

      // no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(REG_MULTIPLIER, 32'd3);
      write_ext_clock(27'($urandom_range(100000000, 1)));
      run_random(100);
      repeat (2) begin
         write_csr(REG_MULTIPLIER, $urandom());
         write_ext_clock(27'($urandom_range(100000000, 1)));
         run_random(100);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("dds_tuning_word_calc_core_tb passed");
      end else begin
         $display("dds_tuning_word_calc_core_tb failed");
      end
      $finish;
   end

endmodule
